FILE: rtl/core/prts_pkg.sv
// shared types, codes and the scoring function of the replay store
`default_nettype none
package prts_pkg;

    localparam int REWARD_W = 16;
    localparam int DIFF_W   = 16;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int BATCH_W  = 7;
    localparam int SCORE_W  = 20;
    localparam int ENTRY_W  = REWARD_W + DIFF_W + TIME_W;

    // opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_APPENDED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd3;

    // register indexes
    localparam logic CFG_BATCH_LIMIT = 1'b0;
    localparam logic CFG_DIFF_TARGET = 1'b1;

    localparam logic [BATCH_W-1:0] BATCH_RESET  = 7'd16;
    localparam logic [DIFF_W-1:0]  TARGET_RESET = 16'd2048;

    // score constants, units of 2^-12
    localparam logic [16:0] NEAR_ONE      = 17'd4096;
    localparam logic [SCORE_W-1:0] BONUS  = 20'd163840;
    localparam logic signed [16:0] BONUS_LO = -17'sd2052;
    localparam logic signed [16:0] BONUS_HI = -17'sd2044;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic begin_pass;
        logic scan_rd;
        logic fetch_rd;
        logic emit_entry;
        logic emit_append;
        logic emit_empty;
    } prts_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic op_sample;
        logic want_zero;
        logic scan_end;
        logic final_pick;
        logic out_free;
    } prts_stat_t;

    // priority of one entry against the difficulty frontier
    function automatic logic [SCORE_W-1:0] entry_score(
        input logic [REWARD_W-1:0] r,
        input logic [DIFF_W-1:0]   d,
        input logic [DIFF_W-1:0]   f
    );
        logic signed [16:0] rs;
        logic signed [16:0] dd;
        logic [16:0] ar;
        logic [16:0] ad;
        logic [SCORE_W-1:0] s;
        rs = {r[15], r};
        dd = $signed({d[15], d}) - $signed({f[15], f});
        ar = rs[16] ? 17'(-rs) : 17'(rs);
        ad = dd[16] ? 17'(-dd) : 17'(dd);
        s  = 20'(ar) * 20'd12;
        if (ad < NEAR_ONE)
        begin
            s = s + 20'(NEAR_ONE - ad);
        end
        if (rs >= BONUS_LO && rs <= BONUS_HI)
        begin
            s = s + BONUS;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/prts_if.sv
// request and result channel interfaces
`default_nettype none
interface prts_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] reward_value;
    logic [15:0] difficulty_value;
    logic [31:0] time_stamp;
    modport source (output valid, opcode, reward_value, difficulty_value, time_stamp,
                    input ready);
    modport sink   (input valid, opcode, reward_value, difficulty_value, time_stamp,
                    output ready);
endinterface

interface prts_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  entry_index;
    logic [15:0] out_reward;
    logic [15:0] out_difficulty;
    logic [31:0] out_timestamp;
    logic        last;
    modport source (output valid, kind, entry_index, out_reward, out_difficulty,
                    out_timestamp, last, input ready);
    modport sink   (input valid, kind, entry_index, out_reward, out_difficulty,
                    out_timestamp, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/prts_datapath.sv
// entry store, selection scan and result register
`default_nettype none
module prts_datapath
    import prts_pkg::*;
#(
    parameter int CAPACITY = 64
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               req_opcode,
    input  wire logic [REWARD_W-1:0] req_reward,
    input  wire logic [DIFF_W-1:0]  req_difficulty,
    input  wire logic [TIME_W-1:0]  req_time,
    input  wire prts_cmd_t          cmd,
    output prts_stat_t              stat,
    input  wire logic               rsp_ready,
    output logic                    rsp_valid,
    output logic [KIND_W-1:0]       rsp_kind,
    output logic [INDEX_W-1:0]      rsp_index,
    output logic [REWARD_W-1:0]     rsp_reward,
    output logic [DIFF_W-1:0]       rsp_difficulty,
    output logic [TIME_W-1:0]       rsp_time,
    output logic                    rsp_last
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // configuration registers
    logic [BATCH_W-1:0] batch_reg;
    logic [DIFF_W-1:0]  target_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg  <= BATCH_RESET;
            target_reg <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BATCH_LIMIT: batch_reg  <= cfg_data[BATCH_W-1:0];
                CFG_DIFF_TARGET: target_reg <= cfg_data;
                default:         batch_reg  <= batch_reg;
            endcase
        end
    end

    // latched request word
    logic                op_reg;
    logic [REWARD_W-1:0] rw_reg;
    logic [DIFF_W-1:0]   df_reg;
    logic [TIME_W-1:0]   ts_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= req_opcode;
            rw_reg <= req_reward;
            df_reg <= req_difficulty;
            ts_reg <= req_time;
        end
    end

    // entry count and picks left
    logic [CW-1:0]      count_reg;
    logic [BATCH_W-1:0] remain_reg;
    logic [BATCH_W-1:0] count_ext;
    logic               full;
    assign count_ext = BATCH_W'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            if (cmd.emit_append && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.load_in)
            begin
                remain_reg <= (batch_reg < count_ext) ? batch_reg : count_ext;
            end
            else if (cmd.emit_entry)
            begin
                remain_reg <= remain_reg - BATCH_W'(1);
            end
        end
    end

    // entry memory, one write and one registered read
    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      best_reg;
    logic [CW-1:0]      scan_ptr_reg;
    assign rd_addr = cmd.fetch_rd ? best_reg : scan_ptr_reg[IW-1:0];
    always_ff @(posedge clk)
    begin
        if (cmd.emit_append && !full)
        begin
            mem[count_reg[IW-1:0]] <= {rw_reg, df_reg, ts_reg};
        end
        if (cmd.scan_rd || cmd.fetch_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // scan pointer and read tag
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_ptr_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            rd_idx_reg <= scan_ptr_reg[IW-1:0];
            if (cmd.begin_pass)
            begin
                scan_ptr_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_ptr_reg <= scan_ptr_reg + CW'(1);
            end
        end
    end

    // running best of one pass
    logic [SCORE_W-1:0]  cur_score;
    logic [SCORE_W-1:0]  best_score_reg;
    logic                found_reg;
    logic [CAPACITY-1:0] taken_reg;
    assign cur_score = entry_score(rd_data_reg[ENTRY_W-1 -: REWARD_W],
                                   rd_data_reg[TIME_W +: DIFF_W], target_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_score_reg <= '0;
            taken_reg      <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                taken_reg <= '0;
            end
            else if (cmd.emit_entry)
            begin
                taken_reg[best_reg] <= 1'b1;
            end
            if (cmd.begin_pass)
            begin
                found_reg <= 1'b0;
            end
            else if (rd_vld_reg && !taken_reg[rd_idx_reg]
                     && (!found_reg || cur_score > best_score_reg))
            begin
                found_reg      <= 1'b1;
                best_reg       <= rd_idx_reg;
                best_score_reg <= cur_score;
            end
        end
    end

    // result register
    logic rsp_free;
    assign rsp_free = !rsp_valid || rsp_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid <= 1'b0;
        end
        else if (cmd.emit_entry || cmd.emit_append || cmd.emit_empty)
        begin
            rsp_valid <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.emit_entry)
        begin
            rsp_kind       <= KIND_SAMPLED;
            rsp_index      <= INDEX_W'(best_reg);
            rsp_reward     <= rd_data_reg[ENTRY_W-1 -: REWARD_W];
            rsp_difficulty <= rd_data_reg[TIME_W +: DIFF_W];
            rsp_time       <= rd_data_reg[TIME_W-1:0];
            rsp_last       <= (remain_reg == BATCH_W'(1));
        end
        else if (cmd.emit_append)
        begin
            rsp_kind       <= full ? KIND_DROPPED : KIND_APPENDED;
            rsp_index      <= full ? '0 : INDEX_W'(count_reg);
            rsp_reward     <= rw_reg;
            rsp_difficulty <= df_reg;
            rsp_time       <= ts_reg;
            rsp_last       <= 1'b1;
        end
        else if (cmd.emit_empty)
        begin
            rsp_kind       <= KIND_EMPTY;
            rsp_index      <= '0;
            rsp_reward     <= '0;
            rsp_difficulty <= '0;
            rsp_time       <= '0;
            rsp_last       <= 1'b1;
        end
    end

    // status to the controller
    assign stat.op_sample  = (op_reg == OP_SAMPLE);
    assign stat.want_zero  = (remain_reg == '0);
    assign stat.scan_end   = (scan_ptr_reg == count_reg - CW'(1));
    assign stat.final_pick = (remain_reg == BATCH_W'(1));
    assign stat.out_free   = rsp_free;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_entry |-> found_reg && !taken_reg[best_reg])
        else $error("pick without a fresh best entry");
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> scan_ptr_reg < count_reg)
        else $error("scan beyond stored entries");
endmodule
`default_nettype wire

FILE: rtl/core/prts_ctrl.sv
// sequencer for append, empty answer and repeated selection passes
`default_nettype none
module prts_ctrl
    import prts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire prts_stat_t stat,
    output prts_cmd_t       cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_APPEND = 8'b0000_0100,
        S_EMPTY  = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_FETCH  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.op_sample)
                begin
                    state_next = S_APPEND;
                end
                else if (stat.want_zero)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    cmd.begin_pass = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_APPEND:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_append = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch_rd = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_entry = 1'b1;
                    if (stat.final_pick)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.begin_pass = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_DECIDE)
        else $error("accepted word not dispatched");
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.emit_entry, cmd.emit_append, cmd.emit_empty}) <= 1)
        else $error("two results loaded at once");
    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_rd && cmd.fetch_rd))
        else $error("scan and fetch read together");
endmodule
`default_nettype wire

FILE: rtl/core/priority_replay_topk_select.sv
// top level of the prioritised replay store with top-k sampling
//
//  channel  dir  handshake          word
//  req      in   valid/ready        opcode, reward, difficulty, time stamp
//  rsp      out  valid/ready        kind, index, reward, difficulty, stamp, last
//  cfg      in   cfg_we only        cfg_index, cfg_data
//
// an append passes the decide and append states before it loads its result;
// the next word is taken back in idle; a sample with k picks over n stored
// entries runs k selection passes, each reading one entry per cycle from the
// single-port store, then passing the drain, fetch and emit states
// reset empties the store; entry contents are kept only below the count
// a stalled result register holds the sequencer before it loads the next word
`default_nettype none
module priority_replay_topk_select
    import prts_pkg::*;
#(
    parameter int CAPACITY = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    prts_req_if.sink         req,
    prts_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    prts_cmd_t  cmd;
    prts_stat_t stat;

    prts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    prts_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_opcode     (req.opcode),
        .req_reward     (req.reward_value),
        .req_difficulty (req.difficulty_value),
        .req_time       (req.time_stamp),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_kind       (rsp.kind),
        .rsp_index      (rsp.entry_index),
        .rsp_reward     (rsp.out_reward),
        .rsp_difficulty (rsp.out_difficulty),
        .rsp_time       (rsp.out_timestamp),
        .rsp_last       (rsp.last)
    );
endmodule
`default_nettype wire

FILE: bench/priority_replay_topk_select_tb.sv
// self-checking bench for the replay store: directed table, register extremes, random appends and samples, full store
`timescale 1ns / 100ps
`default_nettype none
module priority_replay_topk_select_tb
    import prts_pkg::*;
();

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  idx;
        logic [15:0] rw;
        logic [15:0] df;
        logic [31:0] ts;
        logic        last;
    } result_t;

    typedef struct {
        logic        op;
        logic [15:0] rw;
        logic [15:0] df;
        logic [31:0] ts;
        logic        typed;
        logic [1:0]  kind;
        logic [5:0]  idx;
    } row_t;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 20000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_BATCH_LIMIT;
    logic [15:0] cfg_data = '0;

    prts_req_if req ();
    prts_rsp_if rsp ();

    priority_replay_topk_select #(.CAPACITY(STORE_DEPTH)) dut
    (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // shadow of the store and registers
    logic [15:0] shadow_rw [STORE_DEPTH];
    logic [15:0] shadow_df [STORE_DEPTH];
    logic [31:0] shadow_ts [STORE_DEPTH];
    int          shadow_count = 0;
    logic [6:0]  shadow_batch = BATCH_RESET;
    logic [15:0] shadow_target = TARGET_RESET;

    result_t pending_results[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  rsp_stall_on = 1'b1;

    initial
    begin
        req.valid = 1'b0;
        req.opcode = OP_APPEND;
        req.reward_value = '0;
        req.difficulty_value = '0;
        req.time_stamp = '0;
        rsp.ready = 1'b0;
    end

    // priority of a slot, 2^-12 units
    function automatic int slot_priority(int s);
        int r, d, f, near, p;
        r = $signed(shadow_rw[s]);
        d = $signed(shadow_df[s]);
        f = $signed(shadow_target);
        p = 12 * (r < 0 ? -r : r);
        near = 4096 - ((d - f) < 0 ? f - d : d - f);
        if (near > 0)
            p += near;
        if (r + 2048 <= 4 && r + 2048 >= -4)
            p += 163840;
        return p;
    endfunction

    // work out the results of one request word
    task automatic predict_word(input logic op, input logic [15:0] rw,
                                input logic [15:0] df, input logic [31:0] ts);
        int  prio [STORE_DEPTH];
        bit  taken [STORE_DEPTH];
        int  want, best;
        if (op == OP_APPEND)
        begin
            if (shadow_count >= STORE_DEPTH)
                pending_results.push_back({KIND_DROPPED, 6'd0, rw, df, ts, 1'b1});
            else
            begin
                shadow_rw[shadow_count] = rw;
                shadow_df[shadow_count] = df;
                shadow_ts[shadow_count] = ts;
                pending_results.push_back({KIND_APPENDED, 6'(shadow_count), rw, df, ts, 1'b1});
                shadow_count++;
            end
        end
        else
        begin
            want = shadow_batch < shadow_count ? shadow_batch : shadow_count;
            if (want == 0)
                pending_results.push_back({KIND_EMPTY, 6'd0, 16'd0, 16'd0, 32'd0, 1'b1});
            for (int i = 0; i < shadow_count; i++)
            begin
                prio[i] = slot_priority(i);
                taken[i] = 1'b0;
            end
            for (int k = 0; k < want; k++)
            begin
                best = -1;
                for (int i = 0; i < shadow_count; i++)
                    if (!taken[i] && (best < 0 || prio[i] > prio[best]))
                        best = i;
                taken[best] = 1'b1;
                pending_results.push_back({KIND_SAMPLED, 6'(best), shadow_rw[best],
                    shadow_df[best], shadow_ts[best], 1'(k + 1 == want)});
            end
        end
    endtask

    // offer one word, wait for acceptance, after an optional random gap
    task automatic send_word(input logic op, input logic [15:0] rw, input logic [15:0] df,
                             input logic [31:0] ts, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(posedge clk);
        req.valid <= 1'b1;
        req.opcode <= op;
        req.reward_value <= rw;
        req.difficulty_value <= df;
        req.time_stamp <= ts;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_word(op, rw, df, ts);
        req.valid <= 1'b0;
        // the store is busy for this cycle anyway
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_BATCH_LIMIT)
            shadow_batch = value[6:0];
        else
            shadow_target = value;
        @(posedge clk);
    endtask

    // result sink with stall bursts
    always @(posedge clk)
    begin
        result_t seen, want;
        if (rsp.valid && rsp.ready)
        begin
            seen = {rsp.kind, rsp.entry_index, rsp.out_reward, rsp.out_difficulty,
                    rsp.out_timestamp, rsp.last};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", seen);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, seen);
                end
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else if (rsp_stall_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // timeout watch
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // directed rows, kind and index typed in where obvious
    row_t directed [] = '{
        '{OP_SAMPLE, 16'h0000, 16'h0000, 32'h0, 1'b1, KIND_EMPTY, 6'd0},
        '{OP_APPEND, 16'h7fff, 16'h8000, 32'hffffffff, 1'b1, KIND_APPENDED, 6'd0},
        '{OP_APPEND, 16'h8000, 16'h7fff, 32'h00000000, 1'b1, KIND_APPENDED, 6'd1},
        '{OP_APPEND, 16'hf800, 16'h0800, 32'h12345678, 1'b1, KIND_APPENDED, 6'd2},
        '{OP_APPEND, 16'hf7fc, 16'h0000, 32'h00000011, 1'b1, KIND_APPENDED, 6'd3},
        '{OP_APPEND, 16'hf804, 16'h0000, 32'h00000022, 1'b1, KIND_APPENDED, 6'd4},
        '{OP_APPEND, 16'hf7fb, 16'h0000, 32'h00000033, 1'b1, KIND_APPENDED, 6'd5},
        '{OP_APPEND, 16'hf805, 16'h0000, 32'h00000044, 1'b1, KIND_APPENDED, 6'd6},
        '{OP_APPEND, 16'h0000, 16'h0800, 32'h00000055, 1'b1, KIND_APPENDED, 6'd7},
        '{OP_APPEND, 16'h0000, 16'h0800, 32'h00000066, 1'b1, KIND_APPENDED, 6'd8},
        '{OP_APPEND, 16'h0000, 16'h1800, 32'h00000077, 1'b1, KIND_APPENDED, 6'd9},
        '{OP_SAMPLE, 16'h0000, 16'h0000, 32'h0, 1'b0, KIND_SAMPLED, 6'd0}
    };

    task automatic random_word(input bit gaps);
        logic [15:0] rw;
        logic [15:0] df;
        case ($urandom_range(0, 5))
            0: rw = 16'(-2048 + $signed(5'($urandom_range(0, 12)) - 5'd6));
            1: rw = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            2: rw = 16'($urandom_range(0, 7));
            default: rw = 16'($urandom);
        endcase
        df = $urandom_range(0, 1) ? 16'(shadow_target + $urandom_range(0, 8192) - 4096)
                                  : 16'($urandom);
        send_word($urandom_range(0, 9) == 0 ? OP_SAMPLE : OP_APPEND, rw, df,
                  32'($urandom), gaps);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
        begin
            send_word(directed[i].op, directed[i].rw, directed[i].df, directed[i].ts, 1'b1);
            if (directed[i].typed && (pending_results[$].kind !== directed[i].kind ||
                pending_results[$].idx !== directed[i].idx))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d typed result differs from prediction", i);
            end
        end
        drain_results();

        // batch zero and extremes of both registers
        write_register(CFG_BATCH_LIMIT, 16'd0);
        write_register(CFG_DIFF_TARGET, 16'h8000);
        send_word(OP_SAMPLE, 16'h0, 16'h0, 32'h0, 1'b0);
        drain_results();
        write_register(CFG_BATCH_LIMIT, 16'd64);
        write_register(CFG_DIFF_TARGET, 16'h7fff);
        send_word(OP_SAMPLE, 16'h0, 16'h0, 32'h0, 1'b0);
        drain_results();
        write_register(CFG_BATCH_LIMIT, 16'd1);
        write_register(CFG_DIFF_TARGET, 16'h0000);
        send_word(OP_SAMPLE, 16'hffff, 16'hffff, 32'h0, 1'b0);
        drain_results();

        // random phases, each refilled after reset-free settings change
        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(CFG_BATCH_LIMIT, 16'($urandom_range(1, 64)));
            write_register(CFG_DIFF_TARGET, 16'($urandom));
            if (phase == 5)
                rsp_stall_on = 1'b0;
            repeat (60)
                random_word(phase != 5);
            drain_results();
        end

        // full store: a dropped append and a full sample
        send_word(OP_APPEND, 16'h1234, 16'h4321, 32'hdeadbeef, 1'b0);
        drain_results();
        write_register(CFG_BATCH_LIMIT, 16'd64);
        send_word(OP_SAMPLE, 16'h0, 16'h0, 32'h0, 1'b0);
        drain_results();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
